// ===== rtl/wsbh_pkg.sv =====
// ----------------------------------------------------------------------------
// wsbh_pkg: shared types and constants for the word-sum bucket hash
// Field widths, the last divider step and the job record handed from the
// byte accumulator to the serial divider.
// ----------------------------------------------------------------------------
package wsbh_pkg;

	localparam int unsigned SUM_W  = 64;
	localparam int unsigned BKT_W  = 32;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LANE_W = 3;
	localparam int unsigned CNT_W  = 6;

	// last step of the bit-serial divide, one quotient bit per cycle
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);

	// one finished message sum waiting for reduction
	typedef struct packed {
		logic [SUM_W-1:0] dividend;
		logic [BKT_W-1:0] divisor;
	} div_job_t;

endpackage

// ===== rtl/wsbh_if.sv =====
// ----------------------------------------------------------------------------
// wsbh_if: valid/ready channels of the word-sum bucket hash
// Message byte channel, bucket result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface wsbh_msg_if;
	logic                         valid;
	logic                         ready;
	logic [wsbh_pkg::BYTE_W-1:0]  data_byte;
	logic [wsbh_pkg::LANE_W-1:0]  length_low_bits;
	logic                         last;

	modport source (output valid, output data_byte, output length_low_bits,
		output last, input ready);
	modport sink (input valid, input data_byte, input length_low_bits,
		input last, output ready);
endinterface

interface wsbh_res_if;
	logic                        valid;
	logic                        ready;
	logic [wsbh_pkg::BKT_W-1:0]  bucket;

	modport source (output valid, output bucket, input ready);
	modport sink (input valid, input bucket, output ready);
endinterface

interface wsbh_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [wsbh_pkg::BKT_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/wsbh_div.sv =====
// ----------------------------------------------------------------------------
// wsbh_div: bit-serial 64 by 32 remainder unit
// Restoring division, one dividend bit per cycle, with its own result
// register so a finished bucket can wait while the next job starts.
// ----------------------------------------------------------------------------
module wsbh_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	output logic                        job_ready,
	input  wsbh_pkg::div_job_t          job,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [wsbh_pkg::BKT_W-1:0]  res_bucket
);

	typedef enum logic [1:0] {
		IDLE,
		RUN,
		FINISH
	} state_t;

	state_t                          state_q;
	logic [wsbh_pkg::CNT_W-1:0]      cnt_q;
	logic [wsbh_pkg::SUM_W-1:0]      quo_q;
	logic [wsbh_pkg::BKT_W-1:0]      div_q;
	logic [wsbh_pkg::BKT_W-1:0]      rem_q;
	logic [wsbh_pkg::BKT_W-1:0]      bucket_q;
	logic                            res_valid_q;

	logic [wsbh_pkg::BKT_W:0]        shifted;
	logic [wsbh_pkg::BKT_W:0]        diff;
	logic                            take;
	logic [wsbh_pkg::BKT_W-1:0]      rem_nxt;
	logic                            out_free;

	// shift in the next dividend bit and subtract the divisor when it fits
	always_comb begin
		shifted = {rem_q, quo_q[wsbh_pkg::SUM_W-1]};
		diff    = shifted - {1'b0, div_q};
		take    = (shifted >= {1'b0, div_q});
		rem_nxt = take ? diff[wsbh_pkg::BKT_W-1:0] : shifted[wsbh_pkg::BKT_W-1:0];
	end

	assign out_free   = !res_valid_q || res_ready;
	assign job_ready  = (state_q == IDLE);
	assign res_valid  = res_valid_q;
	assign res_bucket = bucket_q;

	// sequence the divide and hold the result until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// drop the result on transfer unless a new one replaces it
			if (res_valid_q && res_ready && state_q != FINISH) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (job_valid) begin
						quo_q   <= job.dividend;
						div_q   <= job.divisor;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= RUN;
					end
				end
				RUN: begin
					quo_q <= {quo_q[wsbh_pkg::SUM_W-2:0], 1'b0};
					rem_q <= rem_nxt;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == wsbh_pkg::CNT_LAST) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (out_free) begin
						bucket_q    <= rem_q;
						res_valid_q <= 1'b1;
						state_q     <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// a taken job starts the divide from step zero
	a_job_starts: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_ready |=> state_q == RUN && cnt_q == '0)
		else $error("divide did not start on job transfer");

	// the partial remainder stays below a nonzero divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == RUN && div_q != '0 |-> rem_q < div_q)
		else $error("partial remainder out of range");

	// a finish with room in the output register publishes the remainder
	a_publish: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FINISH && out_free |=> res_valid_q && bucket_q == $past(rem_q))
		else $error("remainder not published");

	// the step counter only moves while dividing
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FINISH |=> $stable(cnt_q))
		else $error("step counter moved outside the divide");

endmodule

// ===== rtl/word_sum_bucket_hash.sv =====
// ----------------------------------------------------------------------------
// word_sum_bucket_hash: streaming word-sum bucket hash
// Adds message bytes into a 64-bit word sum and reduces the sum modulo the
// configured bucket count when the last byte arrives.
// ----------------------------------------------------------------------------
// Usage:
//   msg  : one message byte per transfer, with length_low_bits (length mod 8,
//          sampled on the first byte only) and last on the final byte.
//   res  : one bucket index per message, the word sum modulo bucket_count.
//   cfg  : write of bucket_count; reset value 1. A zero count passes the low
//          32 bits of the sum through unreduced.
// Throughput: one byte per cycle while msg.ready is high; msg.ready drops after
//   each last byte until the divider takes the sum. The divider takes a sum in
//   IDLE, runs 64 steps of one quotient bit, then publishes the remainder from
//   FINISH once the output register is free.
//   The next message accumulates meanwhile; once its last byte is in,
//   msg.ready stays low until the divider takes that sum; the divider takes no
//   new sum before it has published the last one.
// Stall: a bucket not taken on res stays in the output register; the divider
//   then holds its next remainder until the register frees up.
// Reset: clears the sum and lane state, empties the divider and output, and
//   sets bucket_count to 1.
// ----------------------------------------------------------------------------
module word_sum_bucket_hash (
	input  logic          clk,
	input  logic          arst_n,
	wsbh_msg_if.sink      msg,
	wsbh_res_if.source    res,
	wsbh_cfg_if.sink      cfg
);

	logic [wsbh_pkg::BKT_W-1:0]   bucket_cnt_q;
	logic [wsbh_pkg::SUM_W-1:0]   sum_q;
	logic [wsbh_pkg::LANE_W-1:0]  lane_q;
	logic [wsbh_pkg::LANE_W-1:0]  head_q;
	logic                         start_q;
	wsbh_pkg::div_job_t           job_q;
	logic                         job_valid_q;
	logic                         job_ready;

	logic                         msg_xfer;
	logic [wsbh_pkg::SUM_W-1:0]   sum_base;
	logic [wsbh_pkg::LANE_W-1:0]  lane_cur;
	logic [wsbh_pkg::LANE_W-1:0]  head_cur;
	logic [wsbh_pkg::LANE_W-1:0]  head_dec;
	logic [wsbh_pkg::SUM_W-1:0]   addend;
	logic [wsbh_pkg::SUM_W-1:0]   sum_nxt;
	logic [wsbh_pkg::LANE_W-1:0]  lane_nxt;
	logic [wsbh_pkg::LANE_W-1:0]  head_nxt;

	assign msg_xfer  = msg.valid && msg.ready;
	assign msg.ready = !job_valid_q;
	assign cfg.ready = 1'b1;

	// place the byte in its lane and step the lane and head counters
	always_comb begin
		sum_base = start_q ? '0 : sum_q;
		lane_cur = start_q ? '0 : lane_q;
		head_cur = start_q ? msg.length_low_bits : head_q;
		head_dec = head_cur - 1'b1;
		addend   = wsbh_pkg::SUM_W'(msg.data_byte) << {lane_cur, 3'b000};
		sum_nxt  = sum_base + addend;
		if (head_cur != '0) begin
			head_nxt = head_dec;
			lane_nxt = (head_dec == '0) ? '0 : lane_cur + 1'b1;
		end else begin
			head_nxt = '0;
			lane_nxt = lane_cur + 1'b1;
		end
	end

	// hold the bucket count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_cnt_q <= wsbh_pkg::BKT_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			bucket_cnt_q <= cfg.data;
		end
	end

	// accumulate bytes; on the last one queue the sum for the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			lane_q      <= '0;
			head_q      <= '0;
			start_q     <= 1'b1;
			job_valid_q <= 1'b0;
		end else begin
			if (job_valid_q && job_ready) begin
				job_valid_q <= 1'b0;
			end
			if (msg_xfer) begin
				if (msg.last) begin
					job_q.dividend <= sum_nxt;
					job_q.divisor  <= bucket_cnt_q;
					job_valid_q    <= 1'b1;
					sum_q          <= '0;
					lane_q         <= '0;
					head_q         <= '0;
					start_q        <= 1'b1;
				end else begin
					sum_q   <= sum_nxt;
					lane_q  <= lane_nxt;
					head_q  <= head_nxt;
					start_q <= 1'b0;
				end
			end
		end
	end

	wsbh_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid_q),
		.job_ready  (job_ready),
		.job        (job_q),
		.res_valid  (res.valid),
		.res_ready  (res.ready),
		.res_bucket (res.bucket)
	);

	// a last byte queues a job and reopens the message
	a_last_queues: assert property (@(posedge clk) disable iff (!arst_n)
		msg_xfer && msg.last |=> job_valid_q && start_q)
		else $error("last byte did not queue a job");

	// a fresh message starts with clean lane state
	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> lane_q == '0 && head_q == '0)
		else $error("lane state not cleared at message start");

	// a queued sum is not replaced before the divider takes it
	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q && !job_ready |=> job_valid_q && $stable(job_q))
		else $error("queued job lost");

endmodule
